/* design/audio_minmax_envelope_builder_core_assert.svh */
// Assertion macros for the envelope builder core.
`ifndef AUDIO_MINMAX_ENVELOPE_BUILDER_CORE_ASSERT_SVH
`define AUDIO_MINMAX_ENVELOPE_BUILDER_CORE_ASSERT_SVH

// Checks that an implication holds at every clock edge outside reset.
`define AMEB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after its antecedent.
`define AMEB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/ameb_pkg.sv */
// ----------------------------------------------------------------------------
// ameb_pkg
// Types and constants shared by the waveform envelope builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ameb_pkg;
   localparam int MaxWorking = 4000;
   localparam int AddrW = 12;
   localparam int CountW = 13;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_FINISH = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_NOP = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic signed [15:0] sample;
      logic [11:0] bucket_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [15:0] peak;
      logic [11:0] working_count;
      logic signed [7:0] env_min;
      logic signed [7:0] env_max;
   } rsp_type;

   // Memory port request from the sequencer to the store.
   typedef struct packed {
      logic we;
      logic [AddrW-1:0] waddr;
      logic signed [15:0] wmin;
      logic signed [15:0] wmax;
      logic [AddrW-1:0] raddr;
   } mem_req_type;
endpackage
`default_nettype wire

/* design/ameb_store.sv */
// ----------------------------------------------------------------------------
// ameb_store
// Working bucket store: paired min and max memories, one read and one write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ameb_store
   import ameb_pkg::*;
(
   input wire logic clock,
   input wire mem_req_type mreq,
   output logic signed [15:0] rd_min,
   output logic signed [15:0] rd_max
);
   logic signed [15:0] min_mem [MaxWorking];
   logic signed [15:0] max_mem [MaxWorking];

   always_ff @(posedge clock) begin
      if (mreq.we) begin
         min_mem[mreq.waddr] <= mreq.wmin;
         max_mem[mreq.waddr] <= mreq.wmax;
      end
      rd_min <= min_mem[mreq.raddr];
      rd_max <= max_mem[mreq.raddr];
   end
endmodule
`default_nettype wire

/* design/ameb_divider.sv */
// ----------------------------------------------------------------------------
// ameb_divider
// Restoring divider for 25-bit by 13-bit unsigned quotients, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ameb_divider
   import ameb_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [24:0] dividend,
   input wire logic [CountW-1:0] divisor,
   output logic busy,
   output logic [24:0] quotient
);
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [24:0] q_ff, q_in;
   logic [CountW:0] rem_ff, rem_in;
   logic [CountW-1:0] dv_ff, dv_in;
   logic [CountW+1:0] trial;

   always_comb begin
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      dv_in = dv_ff;
      trial = {rem_ff, q_ff[24]} - {2'b00, dv_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 5'd25;
         q_in = dividend;
         rem_in = '0;
         dv_in = divisor;
      end else if (busy_ff) begin
         if (!trial[CountW+1]) begin
            rem_in = trial[CountW:0];
            q_in = {q_ff[23:0], 1'b1};
         end else begin
            rem_in = {rem_ff[CountW-1:0], q_ff[24]};
            q_in = {q_ff[23:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      dv_ff <= dv_in;
   end

   assign busy = busy_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

/* design/audio_minmax_envelope_builder_core.sv */
// ----------------------------------------------------------------------------
// audio_minmax_envelope_builder_core
// Min/max waveform envelope builder with a folding working store.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ channel (valid/ready) as add, finish or
// read commands; finish and read give one transfer on the rsp_ channel, add
// and the unused command give none. csr_we writes out_count; the user must
// raise it only while the block is idle, which the block itself leaves unchecked.
// An add passes through the add state and returns to idle. A completed
// bucket that fills the store, or that finds it full after a finish, starts
// a fold, which reads each pair of stored buckets and writes back their merge.
// A finish answers through the result state, after any fold and the push of
// a partial bucket. A read outside the range or on an empty store goes
// straight to the result state; otherwise it runs two serial divisions,
// scans its working buckets at one per cycle through the memory read port,
// then builds its answer at scan end and passes it out via the result state.
// One item is in flight at a time; req_ready is low while it is worked on.
// The result sits in an output register and one more result may wait behind
// it; while both are held the block keeps req_ready low. Reset empties the
// store and clears the fill, span, peak and store counts; no clearing pass is
// needed, since only written entries are ever used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module audio_minmax_envelope_builder_core
   import ameb_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output rsp_type rsp_data,
   input wire logic csr_we,
   input wire logic [CountW-1:0] csr_wdata
);
   `include "audio_minmax_envelope_builder_core_assert.svh"

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_ADD    = 12'b000000000010,
      S_FOLDA  = 12'b000000000100,
      S_FOLDB  = 12'b000000001000,
      S_FOLDW  = 12'b000000010000,
      S_PUSH   = 12'b000000100000,
      S_DIV0   = 12'b000001000000,
      S_DIV1   = 12'b000010000000,
      S_SCAN   = 12'b000100000000,
      S_SCANE  = 12'b001000000000,
      S_RESULT = 12'b010000000000,
      S_FIN    = 12'b100000000000
   } state_type;

   state_type st_ff, st_in;
   req_type item_ff, item_in;
   logic [CountW-1:0] oc_ff, oc_in;
   logic signed [15:0] rmin_ff, rmin_in, rmax_ff, rmax_in;
   logic [31:0] fill_ff, fill_in;
   logic [4:0] span_ff, span_in;
   logic [15:0] peak_ff, peak_in;
   logic [AddrW-1:0] nst_ff, nst_in;
   logic [AddrW-1:0] fi_ff, fi_in;
   logic signed [15:0] fa_min_ff, fa_min_in, fa_max_ff, fa_max_in;
   logic after_fold_ff, after_fold_in; // 0: back to idle, 1: push next
   logic push_finish_ff, push_finish_in;
   logic [AddrW-1:0] start_ff, start_in, end_ff, end_in, j_ff, j_in;
   logic signed [15:0] mn_ff, mn_in, mx_ff, mx_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type res_ff, res_in;
   logic res_pend_ff, res_pend_in;

   mem_req_type mreq;
   logic signed [15:0] rd_min, rd_max;
   logic div_start, div_busy;
   logic [24:0] div_dividend, div_q;
   logic [15:0] mag;
   logic [31:0] fill_next;
   logic [AddrW-1:0] half;

   ameb_store u_store (.clock, .mreq, .rd_min, .rd_max);
   ameb_divider u_div (
      .clock, .reset, .start(div_start), .dividend(div_dividend),
      .divisor(oc_ff), .busy(div_busy), .quotient(div_q)
   );

   assign req_ready = (st_ff == S_IDLE) && !res_pend_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;
   assign half = {1'b0, nst_ff[AddrW-1:1]};

   always_comb begin
      st_in = st_ff;
      item_in = item_ff;
      oc_in = csr_we ? csr_wdata : oc_ff;
      rmin_in = rmin_ff;
      rmax_in = rmax_ff;
      fill_in = fill_ff;
      span_in = span_ff;
      peak_in = peak_ff;
      nst_in = nst_ff;
      fi_in = fi_ff;
      fa_min_in = fa_min_ff;
      fa_max_in = fa_max_ff;
      after_fold_in = after_fold_ff;
      push_finish_in = push_finish_ff;
      start_in = start_ff;
      end_in = end_ff;
      j_in = j_ff;
      mn_in = mn_ff;
      mx_in = mx_ff;
      res_in = res_ff;
      res_pend_in = res_pend_ff;
      rv_in = rv_ff;
      rsp_in = rsp_ff;
      mreq = '0;
      div_start = 1'b0;
      div_dividend = '0;
      mag = item_ff.sample[15] ? 16'(-item_ff.sample) : 16'(item_ff.sample);
      fill_next = fill_ff + 32'd1;

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      if (res_pend_ff && (!rv_ff || rsp_ready)) begin
         rv_in = 1'b1;
         rsp_in = res_ff;
         res_pend_in = 1'b0;
      end

      case (st_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               item_in = req_data;
               case (req_data.command)
                  CMD_ADD: st_in = S_ADD;
                  CMD_FINISH: st_in = S_FIN;
                  CMD_READ: begin
                     res_in = '0;
                     res_in.working_count = nst_ff;
                     if ({1'b0, req_data.bucket_index} >= oc_ff) begin
                        res_in.status = ST_RANGE;
                        st_in = S_RESULT;
                     end else if (nst_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        st_in = S_RESULT;
                     end else begin
                        div_start = 1'b1;
                        div_dividend = 25'(req_data.bucket_index) * 25'(nst_ff);
                        st_in = S_DIV0;
                     end
                  end
                  default: st_in = S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            if (mag > peak_ff) begin
               peak_in = mag;
            end
            if (fill_ff == '0) begin
               rmin_in = item_ff.sample;
               rmax_in = item_ff.sample;
            end else begin
               if (item_ff.sample < rmin_ff) rmin_in = item_ff.sample;
               if (item_ff.sample > rmax_ff) rmax_in = item_ff.sample;
            end
            fill_in = fill_next;
            st_in = S_IDLE;
            if (fill_next >= (32'd1 << span_ff)) begin
               if (nst_ff >= AddrW'(MaxWorking)) begin
                  fi_in = '0;
                  after_fold_in = 1'b1;
                  push_finish_in = 1'b0;
                  st_in = S_FOLDA;
               end else begin
                  mreq.we = 1'b1;
                  mreq.waddr = nst_ff;
                  mreq.wmin = (fill_ff == '0 || item_ff.sample < rmin_ff) ?
                     item_ff.sample : rmin_ff;
                  mreq.wmax = (fill_ff == '0 || item_ff.sample > rmax_ff) ?
                     item_ff.sample : rmax_ff;
                  fill_in = '0;
                  nst_in = nst_ff + 1'b1;
                  if (nst_ff + 1'b1 >= AddrW'(MaxWorking)) begin
                     fi_in = '0;
                     after_fold_in = 1'b0;
                     st_in = S_FOLDA;
                  end
               end
            end
         end
         S_FOLDA: begin
            mreq.raddr = {fi_ff[AddrW-2:0], 1'b0};
            if (fi_ff >= half) begin
               if (nst_ff[0]) begin
                  mreq.raddr = nst_ff - 1'b1;
                  st_in = S_FOLDW;
               end else begin
                  nst_in = half;
                  if (span_ff != 5'd31) span_in = span_ff + 5'd1;
                  st_in = after_fold_ff ? S_PUSH : S_IDLE;
               end
            end else begin
               st_in = S_FOLDB;
            end
         end
         S_FOLDB: begin
            mreq.raddr = {fi_ff[AddrW-2:0], 1'b1};
            fa_min_in = rd_min;
            fa_max_in = rd_max;
            st_in = S_FOLDW;
         end
         S_FOLDW: begin
            mreq.we = 1'b1;
            if (fi_ff >= half) begin
               mreq.waddr = half;
               mreq.wmin = rd_min;
               mreq.wmax = rd_max;
               nst_in = half + 1'b1;
               if (span_ff != 5'd31) span_in = span_ff + 5'd1;
               st_in = after_fold_ff ? S_PUSH : S_IDLE;
            end else begin
               mreq.waddr = fi_ff;
               mreq.wmin = (rd_min < fa_min_ff) ? rd_min : fa_min_ff;
               mreq.wmax = (rd_max > fa_max_ff) ? rd_max : fa_max_ff;
               fi_in = fi_ff + 1'b1;
               st_in = S_FOLDA;
            end
         end
         S_FIN: begin
            res_in = '0;
            if (oc_ff == '0) begin
               res_in.status = ST_RANGE;
               res_in.working_count = nst_ff;
               st_in = S_RESULT;
            end else if (fill_ff != '0) begin
               push_finish_in = 1'b1;
               if (nst_ff >= AddrW'(MaxWorking)) begin
                  fi_in = '0;
                  after_fold_in = 1'b1;
                  st_in = S_FOLDA;
               end else begin
                  st_in = S_PUSH;
               end
            end else begin
               res_in.status = (nst_ff == '0) ? ST_EMPTY : ST_OK;
               res_in.peak = (peak_ff == '0) ? 16'd1 : peak_ff;
               res_in.working_count = nst_ff;
               st_in = S_RESULT;
            end
         end
         S_PUSH: begin
            mreq.we = 1'b1;
            mreq.waddr = nst_ff;
            mreq.wmin = rmin_ff;
            mreq.wmax = rmax_ff;
            nst_in = nst_ff + 1'b1;
            fill_in = '0;
            push_finish_in = 1'b0;
            st_in = S_IDLE;
            if (push_finish_ff) begin
               res_in = '0;
               res_in.status = ST_OK;
               res_in.peak = (peak_ff == '0) ? 16'd1 : peak_ff;
               res_in.working_count = nst_ff + 1'b1;
               st_in = S_RESULT;
            end
         end
         S_DIV0: begin
            if (!div_busy) begin
               start_in = div_q[AddrW-1:0];
               div_start = 1'b1;
               div_dividend = (25'(item_ff.bucket_index) + 25'd1) * 25'(nst_ff);
               st_in = S_DIV1;
            end
         end
         S_DIV1: begin
            if (!div_busy) begin
               end_in = div_q[AddrW-1:0];
               j_in = start_ff;
               mreq.raddr = start_ff;
               mn_in = 16'sh7fff;
               mx_in = -16'sh8000;
               if (div_q[AddrW-1:0] > start_ff) begin
                  j_in = start_ff + 1'b1;
                  st_in = S_SCAN;
               end else begin
                  st_in = S_SCANE;
               end
            end
         end
         S_SCAN: begin
            mreq.raddr = j_ff;
            if (rd_min < mn_ff) mn_in = rd_min;
            if (rd_max > mx_ff) mx_in = rd_max;
            j_in = j_ff + 1'b1;
            if (j_ff >= end_ff) begin
               st_in = S_SCANE;
            end
         end
         S_SCANE: begin
            st_in = S_RESULT;
            if (end_ff > start_ff) begin
               res_in.env_min = mn_ff[15:8];
               res_in.env_max = mx_ff[15:8];
            end
         end
         S_RESULT: begin
            res_pend_in = 1'b1;
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               rsp_in = res_ff;
               res_pend_in = 1'b0;
            end
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         oc_ff <= CountW'(2000);
         fill_ff <= '0;
         span_ff <= '0;
         peak_ff <= '0;
         nst_ff <= '0;
         rmin_ff <= '0;
         rmax_ff <= '0;
         rv_ff <= 1'b0;
         res_pend_ff <= 1'b0;
         after_fold_ff <= 1'b0;
         push_finish_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         oc_ff <= oc_in;
         fill_ff <= fill_in;
         span_ff <= span_in;
         peak_ff <= peak_in;
         nst_ff <= nst_in;
         rmin_ff <= rmin_in;
         rmax_ff <= rmax_in;
         rv_ff <= rv_in;
         res_pend_ff <= res_pend_in;
         after_fold_ff <= after_fold_in;
         push_finish_ff <= push_finish_in;
      end
      item_ff <= item_in;
      fi_ff <= fi_in;
      fa_min_ff <= fa_min_in;
      fa_max_ff <= fa_max_in;
      start_ff <= start_in;
      end_ff <= end_in;
      j_ff <= j_in;
      mn_ff <= mn_in;
      mx_ff <= mx_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   `AMEB_ASSERT_IMPL(a_store_bound, clock, reset, 1'b1,
      nst_ff <= AddrW'(MaxWorking), "working store count beyond its depth")
   `AMEB_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready,
      st_ff == S_IDLE, "request accepted outside idle")
   `AMEB_ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && !rsp_ready,
      rv_ff && $stable(rsp_ff), "stalled response changed")
   `AMEB_ASSERT_IMPL(a_pend_valid, clock, reset, res_pend_ff,
      rv_ff, "pending result without a waiting response")
endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the min/max waveform envelope builder. A
// behavioural model of the working store is updated on every accepted
// transfer and predicts each finish and read response. Directed tests
// cover the empty store, sample extremes and register extremes.
// Random traffic with idle cycles and back-pressure on both channels
// follows.
// ----------------------------------------------------------------------------
module tb_top
   import ameb_pkg::*;
();

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   req_type req_data = '0;
   logic rsp_ready = 1'b0;
   logic csr_we = 1'b0;
   logic [CountW-1:0] csr_wdata = '0;
   wire logic req_ready;
   wire logic rsp_valid;
   rsp_type rsp_data;

   audio_minmax_envelope_builder_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Envelope model state.
   logic [CountW-1:0] env_out_count;
   logic signed [15:0] env_run_min, env_run_max;
   int unsigned env_fill, env_span, env_peak, env_stored;
   logic signed [15:0] env_min_store [MaxWorking];
   logic signed [15:0] env_max_store [MaxWorking];

   rsp_type expected_rsp_q [$];
   int fails = 0;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_left = 0;

   task automatic fold_working();
      int unsigned half;
      half = env_stored / 2;
      for (int unsigned i = 0; i < half; i++) begin
         env_min_store[i] = (env_min_store[2*i] < env_min_store[2*i+1]) ?
            env_min_store[2*i] : env_min_store[2*i+1];
         env_max_store[i] = (env_max_store[2*i] > env_max_store[2*i+1]) ?
            env_max_store[2*i] : env_max_store[2*i+1];
      end
      if (env_stored % 2 != 0) begin
         env_min_store[half] = env_min_store[env_stored-1];
         env_max_store[half] = env_max_store[env_stored-1];
         env_stored = half + 1;
      end else begin
         env_stored = half;
      end
      if (env_span < 31) env_span++;
   endtask

   task automatic store_bucket();
      if (env_stored >= MaxWorking) fold_working();
      env_min_store[env_stored] = env_run_min;
      env_max_store[env_stored] = env_run_max;
      env_stored++;
      env_fill = 0;
   endtask

   task automatic queue_expected(input rsp_type e);
      expected_rsp_q.insert(expected_rsp_q.size(), e);
   endtask

   task automatic predict_envelope(input req_type r);
      rsp_type e;
      int s, mag, mn, mx;
      longint unsigned n, first, last;
      e = '0;
      s = r.sample;
      case (r.command)
         CMD_ADD: begin
            mag = (s < 0) ? -s : s;
            if (mag > env_peak) env_peak = mag;
            if (env_fill == 0) begin
               env_run_min = r.sample;
               env_run_max = r.sample;
            end else begin
               if (r.sample < env_run_min) env_run_min = r.sample;
               if (r.sample > env_run_max) env_run_max = r.sample;
            end
            env_fill++;
            if (env_fill >= (32'd1 << env_span)) begin
               store_bucket();
               if (env_stored >= MaxWorking) fold_working();
            end
         end
         CMD_FINISH: begin
            if (env_out_count == 0) begin
               e.status = ST_RANGE;
            end else begin
               if (env_fill > 0) store_bucket();
               e.status = (env_stored == 0) ? ST_EMPTY : ST_OK;
               e.peak = (env_peak > 0) ? env_peak[15:0] : 16'd1;
            end
            e.working_count = env_stored[11:0];
            queue_expected(e);
         end
         CMD_READ: begin
            e.working_count = env_stored[11:0];
            if (r.bucket_index >= env_out_count) begin
               e.status = ST_RANGE;
            end else if (env_stored == 0) begin
               e.status = ST_EMPTY;
            end else begin
               n = env_stored;
               first = longint'(r.bucket_index) * n / env_out_count;
               last = (longint'(r.bucket_index) + 1) * n / env_out_count;
               if (last > n) last = n;
               if (last > first) begin
                  mn = 32767;
                  mx = -32768;
                  for (longint unsigned j = first; j < last; j++) begin
                     if (env_min_store[j] < mn) mn = env_min_store[j];
                     if (env_max_store[j] > mx) mx = env_max_store[j];
                  end
                  e.env_min = mn[15:8];
                  e.env_max = mx[15:8];
               end
            end
            queue_expected(e);
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input req_type r);
      int gap;
      gap = 0;
      if ($urandom_range(99) < snd_idle_pct) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_envelope(r);
   endtask

   task automatic send_cmd(input logic [1:0] cmd, input int s, input int idx);
      req_type r;
      r.command = cmd;
      r.sample = s[15:0];
      r.bucket_index = idx[11:0];
      send_item(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      while (!req_ready) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_out_count(input logic [CountW-1:0] v);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      env_out_count = v;
   endtask

   function automatic req_type random_item();
      req_type r;
      int pick, lim;
      pick = $urandom_range(99);
      r.command = (pick < 70) ? CMD_ADD : (pick < 90) ? CMD_READ :
                  (pick < 95) ? CMD_FINISH : CMD_NOP;
      case ($urandom_range(7))
         0: r.sample = 16'sh8000;
         1: r.sample = 16'sh7fff;
         default: r.sample = 16'($urandom);
      endcase
      lim = (env_out_count > 4096) ? 4095 : int'(env_out_count) - 1;
      if (lim >= 0 && $urandom_range(1) == 1) r.bucket_index = 12'($urandom_range(lim));
      else r.bucket_index = 12'($urandom);
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response transfer");
               fails++;
            end else begin
               rsp_type e;
               e = expected_rsp_q.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_data.status);
                  fails++;
               end
               if (rsp_data.peak !== e.peak) begin
                  $error("peak expected %0d actual %0d", e.peak, rsp_data.peak);
                  fails++;
               end
               if (rsp_data.working_count !== e.working_count) begin
                  $error("working_count expected %0d actual %0d",
                     e.working_count, rsp_data.working_count);
                  fails++;
               end
               if (rsp_data.env_min !== e.env_min) begin
                  $error("env_min expected %0d actual %0d", e.env_min, rsp_data.env_min);
                  fails++;
               end
               if (rsp_data.env_max !== e.env_max) begin
                  $error("env_max expected %0d actual %0d", e.env_max, rsp_data.env_max);
                  fails++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   task automatic test_empty_store();
      send_cmd(CMD_READ, 0, 0);
      send_cmd(CMD_FINISH, 0, 0);
      send_cmd(CMD_NOP, 0, 0);
      send_cmd(CMD_READ, 0, 0);
   endtask

   task automatic test_sample_extremes();
      send_cmd(CMD_ADD, -32768, 0);
      send_cmd(CMD_ADD, 32767, 0);
      send_cmd(CMD_ADD, 0, 0);
      send_cmd(CMD_ADD, -1, 0);
      send_cmd(CMD_FINISH, 0, 0);
      for (int i = 0; i < 4; i++) send_cmd(CMD_READ, 0, i);
      send_cmd(CMD_READ, 0, 4095);
   endtask

   task automatic test_register_extremes();
      write_out_count(13'd0);
      send_cmd(CMD_ADD, 1234, 0);
      send_cmd(CMD_FINISH, 0, 0);
      send_cmd(CMD_READ, 0, 0);
      write_out_count(13'd4096);
      send_cmd(CMD_READ, 0, 4095);
      write_out_count(13'd1);
      send_cmd(CMD_READ, 0, 0);
      send_cmd(CMD_READ, 0, 1);
      write_out_count(13'd8191);
      send_cmd(CMD_READ, 0, 4095);
      write_out_count(13'd2000);
   endtask

   task automatic test_back_pressure();
      wait_idle();
      hold_left = 400;
      for (int i = 0; i < 6; i++) send_cmd(CMD_READ, 0, $urandom_range(2100));
      wait_idle();
   endtask

   task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      for (int i = 0; i < 617; i++) begin
         if (i % 150 == 0) begin
            if ($urandom_range(5) == 0) write_out_count(13'($urandom_range(1, 8)));
            else write_out_count(13'($urandom_range(16, 4096)));
         end
         send_item(random_item());
      end
   endtask

   initial begin
      env_out_count = 13'd2000;
      env_run_min = '0;
      env_run_max = '0;
      env_fill = 0;
      env_span = 0;
      env_peak = 0;
      env_stored = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_sample_extremes();
      test_register_extremes();
      test_back_pressure();
      test_random_traffic(10, 47);
      test_random_traffic(47, 10);
      test_random_traffic(0, 0);
      wait_idle();
      repeat (50) @(posedge clock);
      if (fails == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("status: fail");
      $finish;
   end
endmodule
